FILE: rtl/ihex_pkg.sv
package ihex_pkg;

  localparam int unsigned PosW = 10;
  localparam int unsigned IdxW = PosW - 1;

  localparam logic [PosW-1:0] POS_MAX   = 10'd1023;
  localparam logic [PosW-1:0] HDR_CHARS = 10'd11;

  localparam logic [7:0] START_CHAR = 8'h3A;
  localparam logic [7:0] LF_CHAR    = 8'h0A;
  localparam logic [7:0] CR_CHAR    = 8'h0D;

  // record types that the parser acts on
  localparam logic [7:0] KIND_DATA  = 8'h00;
  localparam logic [7:0] KIND_EOF   = 8'h01;
  localparam logic [7:0] KIND_UBASE = 8'h04;

  // byte slots of the record header and of the first two data bytes
  localparam logic [IdxW-1:0] SLOT_COUNT   = 9'd0;
  localparam logic [IdxW-1:0] SLOT_ADDR_HI = 9'd1;
  localparam logic [IdxW-1:0] SLOT_ADDR_LO = 9'd2;
  localparam logic [IdxW-1:0] SLOT_KIND    = 9'd3;
  localparam logic [IdxW-1:0] SLOT_DATA0   = 9'd4;
  localparam logic [IdxW-1:0] SLOT_DATA1   = 9'd5;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_DONE      = 3'd1,
    EV_END       = 3'd2,
    EV_BAD_START = 3'd3,
    EV_BAD_DIGIT = 3'd4,
    EV_BAD_LEN   = 3'd5,
    EV_BAD_SUM   = 3'd6
  } event_t;

  typedef struct packed {
    logic        write_valid;
    logic [31:0] write_address;
    logic [7:0]  write_data;
    event_t      ev;
  } result_t;

  // hex digit decode: bit 4 set when the character is not a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

FILE: rtl/ihex_decode.sv
module ihex_decode import ihex_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] char_q,
  output result_t    res
);

  logic [PosW-1:0] char_position, char_position_next;
  logic [3:0]      high_nibble, high_nibble_next;
  logic [7:0]      record_length, record_length_next;
  logic [15:0]     record_offset, record_offset_next;
  logic [7:0]      record_kind, record_kind_next;
  logic [7:0]      running_sum, running_sum_next;
  logic [15:0]     upper_base, upper_base_next;
  logic            finished, finished_next;
  logic            last_was_cr, last_was_cr_next;

  logic [4:0]      digit;
  logic [7:0]      pair;
  logic [IdxW-1:0] idx;
  logic [IdxW-1:0] data_end;
  logic [PosW-1:0] line_chars;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= '0;
      high_nibble   <= '0;
      record_length <= '0;
      record_offset <= '0;
      record_kind   <= '0;
      running_sum   <= '0;
      upper_base    <= '0;
      finished      <= 1'b0;
      last_was_cr   <= 1'b0;
    end else if (step) begin
      char_position <= char_position_next;
      high_nibble   <= high_nibble_next;
      record_length <= record_length_next;
      record_offset <= record_offset_next;
      record_kind   <= record_kind_next;
      running_sum   <= running_sum_next;
      upper_base    <= upper_base_next;
      finished      <= finished_next;
      last_was_cr   <= last_was_cr_next;
    end
  end

  always_comb begin
    digit      = hex_digit(char_q);
    pair       = {high_nibble, digit[3:0]};
    idx        = char_position[PosW-1:1] - IdxW'(1);
    data_end   = SLOT_DATA0 + {1'b0, record_length};
    line_chars = HDR_CHARS + {1'b0, record_length, 1'b0};

    char_position_next = char_position;
    high_nibble_next   = high_nibble;
    record_length_next = record_length;
    record_offset_next = record_offset;
    record_kind_next   = record_kind;
    running_sum_next   = running_sum;
    upper_base_next    = upper_base;
    finished_next      = finished;
    last_was_cr_next   = last_was_cr;

    res.write_valid   = 1'b0;
    res.write_address = '0;
    res.write_data    = '0;
    res.ev            = EV_NONE;

    if (!finished) begin
      if (last_was_cr && char_q == LF_CHAR) begin
        last_was_cr_next = 1'b0;
      end else begin
        last_was_cr_next = (char_q == CR_CHAR);
        if (char_q == LF_CHAR || char_q == CR_CHAR) begin
          char_position_next = '0;
          if (char_position == '0) begin
            finished_next = 1'b1;
            res.ev        = EV_END;
          end else if (char_position != line_chars) begin
            finished_next = 1'b1;
            res.ev        = EV_BAD_LEN;
          end else if (record_kind == KIND_EOF) begin
            finished_next = 1'b1;
            res.ev        = EV_END;
          end else if (record_kind == KIND_DATA && running_sum != 8'h00) begin
            finished_next = 1'b1;
            res.ev        = EV_BAD_SUM;
          end else begin
            res.ev = EV_DONE;
          end
        end else if (char_position == '0) begin
          if (char_q != START_CHAR) begin
            finished_next = 1'b1;
            res.ev        = EV_BAD_START;
          end else begin
            record_length_next = '0;
            record_offset_next = '0;
            record_kind_next   = '0;
            running_sum_next   = '0;
            high_nibble_next   = '0;
            char_position_next = PosW'(1);
          end
        end else if (digit[4]) begin
          finished_next = 1'b1;
          res.ev        = EV_BAD_DIGIT;
        end else begin
          if (char_position[0]) begin
            high_nibble_next = digit[3:0];
          end else begin
            if (idx == SLOT_COUNT) begin
              record_length_next = pair;
            end else if (idx == SLOT_ADDR_HI) begin
              record_offset_next = {pair, record_offset[7:0]};
            end else if (idx == SLOT_ADDR_LO) begin
              record_offset_next = {record_offset[15:8], pair};
            end else if (idx == SLOT_KIND) begin
              record_kind_next = pair;
            end else if (idx < data_end) begin
              if (record_kind == KIND_DATA) begin
                res.write_valid    = 1'b1;
                res.write_address  = {upper_base, record_offset};
                res.write_data     = pair;
                record_offset_next = record_offset + 16'd1;
              end else if (record_kind == KIND_UBASE) begin
                if (idx == SLOT_DATA0) begin
                  upper_base_next = {pair, upper_base[7:0]};
                end else if (idx == SLOT_DATA1) begin
                  upper_base_next = {upper_base[15:8], pair};
                end
              end
            end
            if (idx <= data_end) begin
              running_sum_next = running_sum + pair;
            end
          end
          if (char_position < POS_MAX) begin
            char_position_next = char_position + PosW'(1);
          end
        end
      end
    end
  end

endmodule

FILE: rtl/intel_hex_record_parser.sv
// channel  | handshake              | payload
// ---------+------------------------+------------------------------------------------
// input    | in_valid / in_stall    | char_in
// output   | out_valid / out_stall  | write_valid, write_address, write_data, event_res
//
// one transaction in gives exactly one transaction out; one character per cycle sustained while out_stall is low
// a character passes through the input register, then is decoded into the result register
// the decode step is a single pass through ihex_decode between the two registers
// rst (synchronous, active high) clears parser state and both valid flags
// out_stall holds the result register; a new character is still taken while the
//   input register is empty, and in_stall rises only when both registers are full
module intel_hex_record_parser import ihex_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        write_valid,
  output logic [31:0] write_address,
  output logic [7:0]  write_data,
  output logic [2:0]  event_res
);

  // input register
  logic       valid_q;
  logic [7:0] char_q;

  // result register
  result_t res;
  result_t res_q;

  // the held character moves into the result register this cycle
  logic advance;

  assign advance  = valid_q && (!out_valid || !out_stall);
  assign in_stall = valid_q && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (!in_stall) begin
      valid_q <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      char_q <= char_in;
    end
  end

  // parser state and per-character decode
  ihex_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .char_q (char_q),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign write_valid   = res_q.write_valid;
  assign write_address = res_q.write_address;
  assign write_data    = res_q.write_data;
  assign event_res     = res_q.ev;

  // a memory write never carries an event code
  a_write_no_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_valid |-> event_res == EV_NONE)
    else $error("write transaction carries an event code");

  // input side only stalls when the result register is full and held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> valid_q && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // a held character with room downstream shows up as a result next cycle
  a_advance_lands: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("decoded character lost");

  // event codes stay within the defined set
  a_event_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_res <= EV_BAD_SUM)
    else $error("undefined event code");

endmodule
